// ===== rtl/core/billboard_sprite_projection_assert.svh =====
// assertion macros for the billboard sprite projection block
// needs clk and rst_n in the scope of the module that uses them
`ifndef BILLBOARD_SPRITE_PROJECTION_ASSERT_SVH
`define BILLBOARD_SPRITE_PROJECTION_ASSERT_SVH

// same-cycle implication, off during reset
`define BSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsp assertion failed");

// next-cycle implication, off during reset
`define BSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsp assertion failed");

`endif

// ===== rtl/core/bsp_pkg.sv =====
// shared types and constants for the billboard sprite projection block
// no dependencies
package bsp_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PLAYER_X      = 3'd0,
        CFG_PLAYER_Y      = 3'd1,
        CFG_DIR_X         = 3'd2,
        CFG_DIR_Y         = 3'd3,
        CFG_PLANE_X       = 3'd4,
        CFG_PLANE_Y       = 3'd5,
        CFG_SCREEN_WIDTH  = 3'd6,
        CFG_SCREEN_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] player_x;
        logic        [15:0] player_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic        [11:0] screen_width;
        logic        [11:0] screen_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        player_x:      16'd0,
        player_y:      16'd0,
        dir_x:         16'sd16384,
        dir_y:         16'sd0,
        plane_x:       16'sd0,
        plane_y:       16'sd10813,
        screen_width:  12'd640,
        screen_height: 12'd480
    };

    // relative sprite position, signed Q8.8
    typedef struct packed {
        logic signed [16:0] sx;
        logic signed [16:0] sy;
    } entry_t;

    typedef struct packed {
        logic signed [23:0] depth;
        logic signed [15:0] screen_column;
        logic        [15:0] sprite_size;
        logic        [11:0] row_start;
        logic        [11:0] row_end;
        logic        [14:0] column_start;
        logic signed [15:0] column_end;
    } res_t;

    localparam logic [15:0] SIZE_SAT      = 16'hFFFF;
    localparam logic [23:0] DEPTH_POS_MAX = 24'd8388607;
    localparam logic [23:0] DEPTH_NEG_MAG = 24'd8388608;
    localparam logic [23:0] COL_POS_MAX   = 24'd32767;
    localparam logic [23:0] COL_NEG_MAG   = 24'd32768;

endpackage

// ===== rtl/core/bsp_fifo.sv =====
// small register queue used between pipeline sections
// depends on nothing
module bsp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/bsp_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage,
// with overflow flag when the quotient needs more than QW bits; no dependencies
module bsp_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 24,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] out_side
);
    localparam int TW = NW - QW;
    localparam int CW = (TW > DW) ? TW : DW;

    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic          ovf_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];
    logic          vld_reg  [QW+1];

    logic [TW-1:0] top_bits;
    logic          ovf_in;

    // quotient too large when the upper numerator part already reaches the divisor
    assign top_bits = num[NW-1:QW];
    assign ovf_in   = (CW'(top_bits) >= CW'(den));

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DW'(top_bits);
            low_reg[0]  <= num[QW-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf_in;
            side_reg[0] <= in_side;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][QW-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k+1]  <= {low_reg[k][QW-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][QW-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign quo      = q_reg[QW];
    assign ovf      = ovf_reg[QW];
    assign out_side = side_reg[QW];

endmodule

// ===== rtl/core/bsp_front.sv =====
// front part: takes sprite beats, forms the position relative to the player
// and holds them in a short queue; depends on bsp_pkg and bsp_fifo
module bsp_front
    import bsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [15:0] sprite_x,
    input  logic [15:0] sprite_y,
    input  cfg_t        cfg,
    input  logic        q_pop,
    output logic        full,
    output logic        q_valid,
    output entry_t      q_data
);
    entry_t entry;
    logic   q_empty;

    // relative position, signed Q8.8
    always_comb
    begin
        entry.sx = $signed({1'b0, sprite_x}) - $signed({1'b0, cfg.player_x});
        entry.sy = $signed({1'b0, sprite_y}) - $signed({1'b0, cfg.player_y});
    end

    bsp_fifo #(
        .W     ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (entry),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    assign q_valid = !q_empty;

endmodule

// ===== rtl/core/bsp_back.sv =====
// back part: camera transform, three pipelined dividers and window clamping
// depends on bsp_pkg and bsp_div
module bsp_back
    import bsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   q_valid,
    input  entry_t q_data,
    output logic   q_pop,
    input  logic   o_full,
    output logic   o_push,
    output res_t   o_data
);
    logic               en;
    logic signed [15:0] dx, dy, px, py;
    logic        [10:0] hw, hh;

    // stage 1: products
    logic               s1_vld_reg;
    logic signed [32:0] p_dysx_reg, p_dxsy_reg, p_pxsy_reg, p_pysx_reg;
    logic signed [31:0] p_pxdy_reg, p_dxpy_reg;
    // stage 2: numerators and determinant
    logic               s2_vld_reg;
    logic signed [33:0] nx_reg, ny_reg;
    logic signed [32:0] det_reg;
    // stage 3: magnitudes and sum
    logic               s3_vld_reg;
    logic signed [34:0] s3_sum_reg;
    logic        [32:0] s3_ny_mag_reg;
    logic        [31:0] s3_det_mag_reg;
    logic               s3_ny_neg_reg, s3_det_neg_reg, s3_det_zero_reg, s3_ny_zero_reg;
    // stage 4: column numerator product
    logic               s4_vld_reg;
    logic signed [45:0] s4_prod_reg;
    logic        [32:0] s4_ny_mag_reg;
    logic        [31:0] s4_det_mag_reg;
    logic               s4_ny_neg_reg, s4_det_neg_reg, s4_det_zero_reg, s4_ny_zero_reg;
    // stage 5: divider operands
    logic               s5_vld_reg;
    logic        [44:0] s5_prod_mag_reg;
    logic        [32:0] s5_ny_mag_reg;
    logic        [31:0] s5_det_mag_reg;
    logic               s5_dep_neg_reg, s5_col_neg_reg, s5_det_zero_reg, s5_ny_zero_reg;
    // divider outputs
    logic               d1_vld, d1_ovf, d2_vld, d2_ovf, d3_vld, d3_ovf;
    logic        [23:0] d1_q, d2_q;
    logic        [15:0] d3_q;
    logic        [2:0]  d1_side;
    logic        [0:0]  d2_side;
    logic        [39:0] d3_side;
    // stage 6: saturated depth and column
    logic               s6_vld_reg;
    logic        [23:0] s6_mag_reg;
    logic signed [23:0] s6_depth_reg;
    logic signed [15:0] s6_col_reg;
    logic        [23:0] dep_mag, col_cl;
    logic        [16:0] col_mag;
    logic signed [15:0] col_val;
    // final clamp
    logic        [15:0] size;
    logic        [14:0] half;
    logic signed [16:0] rs;
    logic        [16:0] re;
    logic signed [17:0] cs, ce;
    logic signed [15:0] f_col;

    assign en    = !o_full;
    assign q_pop = en && q_valid;
    assign dx    = cfg.dir_x;
    assign dy    = cfg.dir_y;
    assign px    = cfg.plane_x;
    assign py    = cfg.plane_y;
    assign hw    = cfg.screen_width[11:1];
    assign hh    = cfg.screen_height[11:1];

    // valid chain of the transform stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= q_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= d1_vld && d2_vld;
        end
    end

    // transform datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_dysx_reg <= dy * q_data.sx;
            p_dxsy_reg <= dx * q_data.sy;
            p_pxsy_reg <= px * q_data.sy;
            p_pysx_reg <= py * q_data.sx;
            p_pxdy_reg <= px * dy;
            p_dxpy_reg <= dx * py;

            nx_reg  <= 34'(p_dysx_reg) - 34'(p_dxsy_reg);
            ny_reg  <= 34'(p_pxsy_reg) - 34'(p_pysx_reg);
            det_reg <= 33'(p_pxdy_reg) - 33'(p_dxpy_reg);

            s3_sum_reg      <= 35'(ny_reg) + 35'(nx_reg);
            s3_ny_mag_reg   <= ny_reg[33] ? 33'(-ny_reg) : 33'(ny_reg);
            s3_det_mag_reg  <= det_reg[32] ? 32'(-det_reg) : 32'(det_reg);
            s3_ny_neg_reg   <= ny_reg[33];
            s3_det_neg_reg  <= det_reg[32];
            s3_det_zero_reg <= (det_reg == '0);
            s3_ny_zero_reg  <= (ny_reg == '0);

            s4_prod_reg     <= $signed({1'b0, hw}) * s3_sum_reg;
            s4_ny_mag_reg   <= s3_ny_mag_reg;
            s4_det_mag_reg  <= s3_det_mag_reg;
            s4_ny_neg_reg   <= s3_ny_neg_reg;
            s4_det_neg_reg  <= s3_det_neg_reg;
            s4_det_zero_reg <= s3_det_zero_reg;
            s4_ny_zero_reg  <= s3_ny_zero_reg;

            s5_prod_mag_reg <= s4_prod_reg[45] ? 45'(-s4_prod_reg) : 45'(s4_prod_reg);
            s5_ny_mag_reg   <= s4_ny_mag_reg;
            s5_det_mag_reg  <= s4_det_mag_reg;
            s5_dep_neg_reg  <= s4_ny_neg_reg ^ s4_det_neg_reg;
            s5_col_neg_reg  <= s4_prod_reg[45] ^ s4_ny_neg_reg;
            s5_det_zero_reg <= s4_det_zero_reg;
            s5_ny_zero_reg  <= s4_ny_zero_reg;
        end
    end

    // depth = ny * 2^14 / det
    bsp_div #(.NW(47), .DW(32), .QW(24), .SW(3)) u_div_depth (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s5_vld_reg),
        .num      ({14'd0, s5_ny_mag_reg} << 14),
        .den      (s5_det_mag_reg),
        .in_side  ({s5_dep_neg_reg, s5_det_zero_reg, s5_ny_zero_reg}),
        .out_vld  (d1_vld),
        .quo      (d1_q),
        .ovf      (d1_ovf),
        .out_side (d1_side)
    );

    // column = hw * (ny + nx) / ny
    bsp_div #(.NW(45), .DW(33), .QW(24), .SW(1)) u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s5_vld_reg),
        .num      (s5_prod_mag_reg),
        .den      (s5_ny_mag_reg),
        .in_side  (s5_col_neg_reg),
        .out_vld  (d2_vld),
        .quo      (d2_q),
        .ovf      (d2_ovf),
        .out_side (d2_side)
    );

    // saturate depth and column magnitudes by sign; zero det clears depth, zero det or ny centres the column
    always_comb
    begin
        if (d1_side[2])
        begin
            dep_mag = (d1_ovf || d1_q > DEPTH_NEG_MAG) ? DEPTH_NEG_MAG : d1_q;
        end
        else
        begin
            dep_mag = (d1_ovf || d1_q > DEPTH_POS_MAX) ? DEPTH_POS_MAX : d1_q;
        end
        if (d1_side[1])
        begin
            dep_mag = '0;
        end
        if (d2_side[0])
        begin
            col_cl = (d2_ovf || d2_q > COL_NEG_MAG) ? COL_NEG_MAG : d2_q;
        end
        else
        begin
            col_cl = (d2_ovf || d2_q > COL_POS_MAX) ? COL_POS_MAX : d2_q;
        end
        col_mag = col_cl[16:0];
        col_val = d2_side[0] ? 16'(17'd0 - col_mag) : 16'(col_mag);
        if (d1_side[1] || d1_side[0])
        begin
            col_val = $signed({5'd0, hw});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_mag_reg   <= dep_mag;
            s6_depth_reg <= d1_side[2] ? $signed(24'd0 - dep_mag) : $signed(dep_mag);
            s6_col_reg   <= col_val;
        end
    end

    // size = height * 256 / |depth|, zero depth overflows to saturation
    bsp_div #(.NW(20), .DW(24), .QW(16), .SW(40)) u_div_size (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .num      ({cfg.screen_height, 8'd0}),
        .den      (s6_mag_reg),
        .in_side  ({s6_depth_reg, s6_col_reg}),
        .out_vld  (d3_vld),
        .quo      (d3_q),
        .ovf      (d3_ovf),
        .out_side (d3_side)
    );

    // window clamping into the result beat
    always_comb
    begin
        size  = d3_ovf ? SIZE_SAT : d3_q;
        half  = size[15:1];
        f_col = d3_side[15:0];
        rs    = $signed({6'd0, hh}) - $signed({2'd0, half});
        re    = {6'd0, hh} + {2'd0, half};
        cs    = 18'(f_col) - $signed({3'd0, half});
        ce    = 18'(f_col) + $signed({3'd0, half});

        o_data.depth         = d3_side[39:16];
        o_data.screen_column = f_col;
        o_data.sprite_size   = size;
        o_data.row_start     = rs[16] ? 12'd0 : rs[11:0];
        if (re >= {5'd0, cfg.screen_height})
        begin
            o_data.row_end = (cfg.screen_height == '0) ? 12'd0
                                                       : cfg.screen_height - 12'd1;
        end
        else
        begin
            o_data.row_end = re[11:0];
        end
        o_data.column_start = cs[17] ? 15'd0 : cs[14:0];
        if (ce >= $signed({6'd0, cfg.screen_width}))
        begin
            o_data.column_end = $signed({4'd0, cfg.screen_width} - 16'd1);
        end
        else
        begin
            o_data.column_end = ce[15:0];
        end
    end

    assign o_push = en && d3_vld;

endmodule

// ===== rtl/core/billboard_sprite_projection.sv =====
// top level of the billboard sprite projection block: configuration registers,
// front queue, back pipeline and result queue; depends on bsp_pkg and all bsp_* modules
//
//  channel   handshake            payload
//  input     push / full          sprite_x, sprite_y
//  result    empty / pop          depth, screen_column, sprite_size, row/column bounds
//  config    cfg_we               cfg_index, cfg_data
//
// one sprite per cycle sustained while the result queue is not full
// the divider chain computes 24 depth quotient bits, then 16 size bits
// reset empties both queues and the pipeline and loads the default camera
// a full result queue freezes the whole back pipeline; the front queue takes beats until it fills
`include "billboard_sprite_projection_assert.svh"

module billboard_sprite_projection
    import bsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic        [15:0] sprite_x,
    input  logic        [15:0] sprite_y,
    output logic               empty,
    input  logic               pop,
    output logic signed [23:0] depth,
    output logic signed [15:0] screen_column,
    output logic        [15:0] sprite_size,
    output logic        [11:0] row_start,
    output logic        [11:0] row_end,
    output logic        [14:0] column_start,
    output logic signed [15:0] column_end,
    input  logic               cfg_we,
    input  logic        [2:0]  cfg_index,
    input  logic        [15:0] cfg_data
);
    cfg_t   cfg_reg, cfg_next;
    logic   q_valid, q_pop;
    entry_t q_data;
    logic   o_push, o_full;
    res_t   o_data, r_data;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PLAYER_X:      cfg_next.player_x      = cfg_data;
                CFG_PLAYER_Y:      cfg_next.player_y      = cfg_data;
                CFG_DIR_X:         cfg_next.dir_x         = cfg_data;
                CFG_DIR_Y:         cfg_next.dir_y         = cfg_data;
                CFG_PLANE_X:       cfg_next.plane_x       = cfg_data;
                CFG_PLANE_Y:       cfg_next.plane_y       = cfg_data;
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[11:0];
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[11:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bsp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .sprite_x (sprite_x),
        .sprite_y (sprite_y),
        .cfg      (cfg_reg),
        .q_pop    (q_pop),
        .full     (full),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    bsp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_data  (o_data)
    );

    // result queue decouples the pipeline from the consumer
    bsp_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (2)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_push),
        .wr_data (o_data),
        .rd_en   (pop),
        .rd_data (r_data),
        .full    (o_full),
        .empty   (empty)
    );

    assign depth         = r_data.depth;
    assign screen_column = r_data.screen_column;
    assign sprite_size   = r_data.sprite_size;
    assign row_start     = r_data.row_start;
    assign row_end       = r_data.row_end;
    assign column_start  = r_data.column_start;
    assign column_end    = r_data.column_end;

    // checks
    `BSP_ASSERT_IMP(a_out_no_overflow, o_push, !o_full)
    `BSP_ASSERT_NXT(a_accept_queued, push && !full, q_valid)
    `BSP_ASSERT_NXT(a_result_held, o_push && !pop, !empty)

endmodule
